FILE: rtl/core/twsag_pkg.sv
// Shared types and constants for the tube waveshaper with supply sag.
package twsag_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int FRAC_BITS_DEF   = 24;
   localparam int LEVEL_W         = 17;
   localparam int CSR_IDX_W       = 2;

   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 17'd32768;
   localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 17'd65536;

   localparam logic [CSR_IDX_W-1:0] CSR_PREAMP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PRE_G,
      ST_PRE_KNEE,
      ST_PRE_HI,
      ST_PRE_HI_POST,
      ST_PRE_LO_POST,
      ST_DRV_G,
      ST_DRV_PRE,
      ST_DRV_POST,
      ST_CLIP_PRE,
      ST_CLIP_POST,
      ST_ENV_A,
      ST_ENV_B,
      ST_SAG_H,
      ST_SAG_O,
      ST_PWR_PRE,
      ST_PWR_POST,
      ST_PWR_SQ,
      ST_PWR_EH,
      ST_XF_CHK,
      ST_XF_PRE,
      ST_XF_POST,
      ST_XF_SQ,
      ST_XF_ADD,
      ST_MST_SQ,
      ST_MST_Y,
      ST_OUT,
      ST_T_CHK,
      ST_T_SQ,
      ST_T_DIV,
      ST_T_MUL
   } state_type;

endpackage

FILE: rtl/core/tube_waveshaper_with_sag_top.sv
// Tube waveshaper with supply sag: sequencer around one shared multiplier and divider.
// Each sample takes up to 32 multiplies on the shared multiply unit, up to five
// rational-tanh divisions on the one-bit-per-cycle restoring divider, and decision
// states. The next sample is accepted only once the sequencer has loaded the result
// (after any previous result has been taken) and has returned to idle.
// req_ready is high only while the sequencer is idle.
// Reset (synchronous, active high) sets all levels to 0.5, clears the sag envelope,
// drops any pending result and returns the sequencer to idle.
module tube_waveshaper_with_sag_top #(
   parameter int SAMPLE_BITS = twsag_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = twsag_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample_out,
   input  logic                               csr_we,
   input  logic [twsag_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [twsag_pkg::LEVEL_W-1:0]      csr_wdata
);
   import twsag_pkg::*;

   localparam int SH     = FRAC_BITS - (SAMPLE_BITS - 1);
   localparam int SHL_IN = (SH > 0) ? SH : 0;
   localparam int SHR_IN = (SH < 0) ? -SH : 0;
   localparam int VW     = (FRAC_BITS + 10 > 34) ? FRAC_BITS + 10 : 34;
   localparam int MW     = VW - 1;
   localparam int NCH    = (MW + 15) / 16;
   localparam int BW     = NCH * 16;
   localparam int AW     = MW + BW;
   localparam int DNW    = FRAC_BITS + 8;
   localparam int QW     = FRAC_BITS + 1;
   localparam int DCW    = $clog2(FRAC_BITS + 1);
   localparam int MCW    = $clog2(NCH + 1);
   localparam int YW     = VW + SHR_IN + 1;

   localparam logic signed [VW-1:0] K_ONE  = VW'(longint'(1) << FRAC_BITS);
   localparam logic signed [VW-1:0] K_3    = VW'(longint'(3) << FRAC_BITS);
   localparam logic signed [VW-1:0] K_27   = VW'(longint'(27) << FRAC_BITS);
   localparam logic signed [VW-1:0] K_QMAX = VW'((longint'(1) << (FRAC_BITS + 7)) - 1);
   localparam logic signed [VW-1:0] K_QMIN = VW'(-(longint'(1) << (FRAC_BITS + 7)));
   localparam logic signed [VW-1:0] K_0P7  = VW'(((longint'(7) << FRAC_BITS) + 5) / 10);
   localparam logic signed [VW-1:0] K_0P8  = VW'(((longint'(8) << FRAC_BITS) + 5) / 10);
   localparam logic signed [VW-1:0] K_1P5  = VW'(((longint'(3) << FRAC_BITS) + 1) / 2);
   localparam logic signed [VW-1:0] K_2D3  = VW'(((longint'(2) << FRAC_BITS) + 1) / 3);
   localparam logic signed [VW-1:0] K_0P5  = VW'(((longint'(1) << FRAC_BITS) + 1) / 2);
   localparam logic signed [VW-1:0] K_1P25 = VW'(((longint'(5) << FRAC_BITS) + 2) / 4);
   localparam logic signed [VW-1:0] K_1P2  = VW'(((longint'(12) << FRAC_BITS) + 5) / 10);
   localparam logic signed [VW-1:0] K_0P83 = VW'(((longint'(83) << FRAC_BITS) + 50) / 100);
   localparam logic signed [VW-1:0] K_0P9  = VW'(((longint'(9) << FRAC_BITS) + 5) / 10);
   localparam logic signed [VW-1:0] K_1P1  = VW'(((longint'(11) << FRAC_BITS) + 5) / 10);
   localparam logic signed [VW-1:0] K_0P3  = VW'(((longint'(3) << FRAC_BITS) + 5) / 10);
   localparam logic signed [VW-1:0] K_0P99 = VW'(((longint'(99) << FRAC_BITS) + 50) / 100);
   localparam logic signed [VW-1:0] K_0P01 = VW'(((longint'(1) << FRAC_BITS) + 50) / 100);
   localparam logic signed [VW-1:0] K_5D6  = VW'(((longint'(5) << FRAC_BITS) + 3) / 6);
   localparam logic signed [VW-1:0] K_0P05 = VW'(((longint'(5) << FRAC_BITS) + 50) / 100);
   localparam logic signed [VW-1:0] K_0P02 = VW'(((longint'(2) << FRAC_BITS) + 50) / 100);
   localparam logic signed [VW-1:0] K_ENVMAX = VW'(longint'(32'hFFFF_FFFF));

   localparam logic [AW-1:0] R_HALF = AW'(longint'(1) << (FRAC_BITS - 1));
   localparam logic [AW-1:0] R_QMAX = AW'((longint'(1) << (FRAC_BITS + 7)) - 1);
   localparam logic [AW-1:0] R_QLIM = AW'(longint'(1) << (FRAC_BITS + 7));

   localparam logic signed [YW-1:0] Y_RND  = YW'((SH > 0) ? (longint'(1) << (SHL_IN - 1)) : 0);
   localparam logic signed [YW-1:0] Y_SMAX = YW'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [YW-1:0] Y_SMIN = YW'(-(longint'(1) << (SAMPLE_BITS - 1)));

   function automatic logic signed [VW-1:0] sat_q(input logic signed [VW-1:0] v);
      logic signed [VW-1:0] r;
      r = v;
      if (v > K_QMAX) r = K_QMAX;
      if (v < K_QMIN) r = K_QMIN;
      return r;
   endfunction

   function automatic logic signed [VW-1:0] abs_v(input logic signed [VW-1:0] v);
      return v[VW-1] ? -v : v;
   endfunction

   function automatic logic signed [VW-1:0] level_q(input logic [LEVEL_W-1:0] lv);
      logic [LEVEL_W-1:0] c;
      c = lv[LEVEL_W-1] ? LEVEL_FULL : lv;
      return VW'(c) <<< (FRAC_BITS - 16);
   endfunction

   // control state
   state_type             state_ff, state_in, ret_ff;
   logic                  wait_ff, wait_in;
   logic [LEVEL_W-1:0]    preamp_ff, drive_ff, master_ff;
   logic [31:0]           env_ff;
   logic                  rsp_valid_ff;
   logic                  mul_busy_ff;
   logic [MCW-1:0]        mul_cnt_ff;

   // payload
   logic signed [VW-1:0]  acc_ff, tmp_ff, rt_x_ff, rt_s_ff, tres_ff;
   logic                  env_up_ff, vneg_ff;
   logic [MW-1:0]         mul_a_ff;
   logic [BW-1:0]         mul_b_ff;
   logic                  mul_neg_ff;
   logic [AW-1:0]         mul_acc_ff;
   logic [DNW:0]          div_rem_ff;
   logic [DNW-1:0]        div_d_ff;
   logic [QW-1:0]         div_q_ff;
   logic [DCW-1:0]        div_cnt_ff;
   logic signed [SAMPLE_BITS-1:0] out_ff;

   // combinational
   logic signed [VW-1:0]  op_a, op_b, mul_res, a_abs, x_conv, x2, env_sum;
   logic signed [VW-1:0]  op_a_mag, op_b_mag;
   logic                  st_mul, mul_go, mul_done;
   logic [AW-1:0]         mul_r;
   logic [MW+15:0]        mul_pp;
   logic [DNW:0]          rem_sh, rem_nx;
   logic                  div_ge;
   logic signed [YW-1:0]  y_wide;
   logic signed [SAMPLE_BITS-1:0] y_sat;

   assign a_abs    = abs_v(acc_ff);
   assign op_a_mag = abs_v(op_a);
   assign op_b_mag = abs_v(op_b);
   assign x_conv   = (VW'(req_sample_in) <<< SHL_IN) >>> SHR_IN;
   assign mul_done = mul_busy_ff && (mul_cnt_ff == MCW'(NCH));
   assign mul_go   = st_mul && !wait_ff;
   assign x2       = mul_res;
   assign env_sum  = tmp_ff + mul_res;

   // round, shift and saturate the magnitude product
   always_comb begin
      mul_r = (mul_acc_ff + R_HALF) >> FRAC_BITS;
      if (!mul_neg_ff) begin
         mul_res = (mul_r > R_QMAX) ? K_QMAX : $signed(mul_r[VW-1:0]);
      end else begin
         mul_res = (mul_r > R_QLIM) ? K_QMIN : -$signed(mul_r[VW-1:0]);
      end
   end

   assign mul_pp = (MW+16)'(mul_a_ff) * (MW+16)'(mul_b_ff[BW-1 -: 16]);

   // one restoring divider step
   always_comb begin
      rem_sh = (div_cnt_ff == '0) ? div_rem_ff : (div_rem_ff << 1);
      div_ge = rem_sh >= {1'b0, div_d_ff};
      rem_nx = div_ge ? (rem_sh - {1'b0, div_d_ff}) : rem_sh;
   end

   // output conversion and saturation
   always_comb begin
      y_wide = ((YW'(acc_ff) + Y_RND) >>> SHL_IN) <<< SHR_IN;
      if (y_wide > Y_SMAX) y_sat = Y_SMAX[SAMPLE_BITS-1:0];
      else if (y_wide < Y_SMIN) y_sat = Y_SMIN[SAMPLE_BITS-1:0];
      else y_sat = y_wide[SAMPLE_BITS-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PRE_G;
         end
         ST_PRE_KNEE: begin
            if (acc_ff > K_0P7) state_in = ST_PRE_HI;
            else if (acc_ff < -K_0P8) state_in = ST_T_CHK;
            else state_in = ST_DRV_G;
         end
         ST_XF_CHK: begin
            state_in = (a_abs > K_0P5) ? ST_XF_PRE : ST_XF_SQ;
         end
         ST_T_CHK: begin
            state_in = (abs_v(rt_x_ff) > K_3) ? ret_ff : ST_T_SQ;
         end
         ST_T_DIV: begin
            if (div_cnt_ff == DCW'(FRAC_BITS)) state_in = ST_T_MUL;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            if (!wait_ff) begin
               wait_in = 1'b1;
            end else if (mul_done) begin
               wait_in = 1'b0;
               case (state_ff)
                  ST_PRE_G:       state_in = ST_PRE_KNEE;
                  ST_PRE_HI:      state_in = ST_T_CHK;
                  ST_PRE_HI_POST: state_in = ST_DRV_G;
                  ST_PRE_LO_POST: state_in = ST_DRV_G;
                  ST_DRV_G:       state_in = ST_DRV_PRE;
                  ST_DRV_PRE:     state_in = ST_T_CHK;
                  ST_DRV_POST:    state_in = ST_CLIP_PRE;
                  ST_CLIP_PRE:    state_in = ST_T_CHK;
                  ST_CLIP_POST:   state_in = ST_ENV_A;
                  ST_ENV_A:       state_in = ST_ENV_B;
                  ST_ENV_B:       state_in = ST_SAG_H;
                  ST_SAG_H:       state_in = ST_SAG_O;
                  ST_SAG_O:       state_in = ST_PWR_PRE;
                  ST_PWR_PRE:     state_in = ST_T_CHK;
                  ST_PWR_POST:    state_in = ST_PWR_SQ;
                  ST_PWR_SQ:      state_in = ST_PWR_EH;
                  ST_PWR_EH:      state_in = ST_XF_CHK;
                  ST_XF_PRE:      state_in = ST_T_CHK;
                  ST_XF_POST:     state_in = ST_XF_SQ;
                  ST_XF_SQ:       state_in = ST_XF_ADD;
                  ST_XF_ADD:      state_in = ST_MST_SQ;
                  ST_MST_SQ:      state_in = ST_MST_Y;
                  ST_MST_Y:       state_in = ST_OUT;
                  ST_T_SQ:        state_in = ST_T_DIV;
                  ST_T_MUL:       state_in = ret_ff;
                  default:        state_in = ST_IDLE;
               endcase
            end
         end
      endcase
   end

   // multiply operands for each step
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      st_mul = 1'b1;
      unique case (state_ff)
         ST_PRE_G:       begin op_a = acc_ff; op_b = K_ONE + level_q(preamp_ff) * VW'(19); end
         ST_PRE_HI:      begin op_a = acc_ff - K_0P7; op_b = K_1P5; end
         ST_PRE_HI_POST: begin op_a = tres_ff; op_b = K_2D3; end
         ST_PRE_LO_POST: begin op_a = tres_ff; op_b = K_0P5; end
         ST_DRV_G:       begin op_a = acc_ff; op_b = K_ONE + level_q(drive_ff) * VW'(20); end
         ST_DRV_PRE:     begin op_a = acc_ff; op_b = (acc_ff > 0) ? K_0P8 : K_1P2; end
         ST_DRV_POST:    begin op_a = tres_ff; op_b = (acc_ff > 0) ? K_1P25 : K_0P83; end
         ST_CLIP_PRE:    begin op_a = acc_ff; op_b = K_0P9; end
         ST_CLIP_POST:   begin op_a = tres_ff; op_b = K_1P1; end
         ST_ENV_A: begin
            op_a = VW'(env_ff);
            op_b = (a_abs > VW'(env_ff)) ? K_0P7 : K_0P99;
         end
         ST_ENV_B:       begin op_a = a_abs; op_b = env_up_ff ? K_0P3 : K_0P01; end
         ST_SAG_H:       begin op_a = VW'(env_ff); op_b = K_0P3; end
         ST_SAG_O:       begin op_a = acc_ff; op_b = K_ONE - tmp_ff; end
         ST_PWR_PRE:     begin op_a = acc_ff; op_b = K_1P2; end
         ST_PWR_POST:    begin op_a = tres_ff; op_b = K_5D6; end
         ST_PWR_SQ:      begin op_a = acc_ff; op_b = acc_ff; end
         ST_PWR_EH:      begin op_a = tmp_ff; op_b = K_0P05; end
         ST_XF_PRE:      begin op_a = acc_ff; op_b = K_0P8; end
         ST_XF_POST:     begin op_a = tres_ff; op_b = K_1P25; end
         ST_XF_SQ:       begin op_a = acc_ff; op_b = a_abs; end
         ST_XF_ADD:      begin op_a = tmp_ff; op_b = K_0P02; end
         ST_MST_SQ:      begin op_a = level_q(master_ff); op_b = level_q(master_ff); end
         ST_MST_Y:       begin op_a = acc_ff; op_b = tmp_ff; end
         ST_T_SQ:        begin op_a = rt_s_ff; op_b = rt_s_ff; end
         ST_T_MUL:       begin op_a = rt_s_ff; op_b = VW'(div_q_ff); end
         default:        st_mul = 1'b0;
      endcase
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = out_ff;

   // control registers, levels, envelope and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= 1'b0;
         preamp_ff    <= LEVEL_RESET;
         drive_ff     <= LEVEL_RESET;
         master_ff    <= LEVEL_RESET;
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mul_busy_ff  <= 1'b0;
         mul_cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_PREAMP: preamp_ff <= csr_wdata;
               CSR_DRIVE:  drive_ff  <= csr_wdata;
               CSR_MASTER: master_ff <= csr_wdata;
               default:    ;
            endcase
         end
         // advance the shared multiplier
         if (mul_go) begin
            mul_busy_ff <= 1'b1;
            mul_cnt_ff  <= '0;
         end else if (mul_done) begin
            mul_busy_ff <= 1'b0;
         end else if (mul_busy_ff) begin
            mul_cnt_ff <= mul_cnt_ff + MCW'(1);
         end
         // update the sag envelope
         if (state_ff == ST_ENV_B && wait_ff && mul_done) begin
            env_ff <= (env_sum > K_ENVMAX) ? 32'hFFFF_FFFF : env_sum[31:0];
         end
         // drop a taken result, then load a fresh one
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) out_ff <= y_sat;

      // latch operand magnitudes, then accumulate one 16-bit chunk per cycle
      if (mul_go) begin
         mul_a_ff   <= op_a_mag[MW-1:0];
         mul_b_ff   <= BW'(op_b_mag[MW-1:0]);
         mul_neg_ff <= op_a[VW-1] ^ op_b[VW-1];
         mul_acc_ff <= '0;
      end else if (mul_busy_ff && !mul_done) begin
         mul_acc_ff <= (mul_acc_ff << 16) + AW'(mul_pp);
         mul_b_ff   <= mul_b_ff << 16;
      end

      // restoring division, one quotient bit per cycle
      if (state_ff == ST_T_DIV) begin
         div_rem_ff <= rem_nx;
         div_q_ff   <= (div_cnt_ff == '0) ? QW'(div_ge) : {div_q_ff[QW-2:0], div_ge};
         div_cnt_ff <= div_cnt_ff + DCW'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) acc_ff <= x_conv;
         end
         ST_PRE_KNEE: begin
            if (!(acc_ff > K_0P7) && acc_ff < -K_0P8) begin
               rt_x_ff <= (acc_ff + K_0P8) <<< 1;
               ret_ff  <= ST_PRE_LO_POST;
            end
         end
         ST_T_CHK: begin
            rt_s_ff <= abs_v(rt_x_ff);
            tres_ff <= rt_x_ff[VW-1] ? -K_ONE : K_ONE;
         end
         default: ;
      endcase

      if (wait_ff && mul_done) begin
         case (state_ff)
            ST_PRE_G:       acc_ff <= mul_res;
            ST_PRE_HI:      begin rt_x_ff <= mul_res; ret_ff <= ST_PRE_HI_POST; end
            ST_PRE_HI_POST: acc_ff <= K_0P7 + mul_res;
            ST_PRE_LO_POST: acc_ff <= mul_res - K_0P8;
            ST_DRV_G:       acc_ff <= mul_res;
            ST_DRV_PRE:     begin rt_x_ff <= mul_res; ret_ff <= ST_DRV_POST; end
            ST_DRV_POST:    acc_ff <= mul_res;
            ST_CLIP_PRE:    begin rt_x_ff <= mul_res; ret_ff <= ST_CLIP_POST; end
            ST_CLIP_POST:   acc_ff <= mul_res;
            ST_ENV_A: begin
               tmp_ff    <= mul_res;
               env_up_ff <= a_abs > VW'(env_ff);
            end
            ST_SAG_H:       tmp_ff <= mul_res;
            ST_SAG_O: begin
               vneg_ff <= acc_ff[VW-1];
               acc_ff  <= mul_res;
            end
            ST_PWR_PRE:     begin rt_x_ff <= mul_res; ret_ff <= ST_PWR_POST; end
            ST_PWR_POST:    acc_ff <= mul_res;
            ST_PWR_SQ:      tmp_ff <= mul_res;
            ST_PWR_EH:      acc_ff <= sat_q(acc_ff + (vneg_ff ? -mul_res : mul_res));
            ST_XF_PRE:      begin rt_x_ff <= mul_res; ret_ff <= ST_XF_POST; end
            ST_XF_POST:     acc_ff <= mul_res;
            ST_XF_SQ:       tmp_ff <= mul_res;
            ST_XF_ADD:      acc_ff <= sat_q(acc_ff + mul_res);
            ST_MST_SQ:      tmp_ff <= mul_res;
            ST_MST_Y:       acc_ff <= mul_res;
            ST_T_SQ: begin
               div_rem_ff <= {1'b0, DNW'(K_27 + x2)};
               div_d_ff   <= DNW'(K_27 + x2 * VW'(9));
               div_q_ff   <= '0;
               div_cnt_ff <= '0;
            end
            ST_T_MUL:       tres_ff <= rt_x_ff[VW-1] ? -mul_res : mul_res;
            default: ;
         endcase
      end
   end

endmodule
